@@ rtl/fct_pkg.sv @@
`default_nettype none
package fct_pkg;

   localparam int DEF_MAX_ENTRIES = 1024;

   localparam int LINK_W  = 12;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 10;
   localparam int FUNC_W  = 3;
   localparam int DC_W    = 10;
   localparam int POS_W   = 13;

   localparam logic [LINK_W-1:0] END_MARK   = 12'hFFF;
   localparam logic [LINK_W-1:0] MEDIA_LINK = 12'hFF9;
   localparam logic [DC_W-1:0]   DC_RESET   = 10'd713;

   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FIND1 = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND2 = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 3'd5;

   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic rd_cur;
      logic take_read;
      logic wr_cur;
      logic chain_rd;
      logic chain_wr;
      logic set_err;
      logic scan_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic chain_stop;
      logic end_mark;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/fct_datapath.sv @@
`default_nettype none
module fct_datapath import fct_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [INDEX_W-1:0]  req_index,
   input  wire logic [LINK_W-1:0]   req_value,
   input  wire logic                csr_valid,
   input  wire logic [DC_W-1:0]     csr_data,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [LINK_W-1:0]        rsp_link,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic                     rsp_err
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_ENTRIES);
   localparam logic [AW-1:0]    LAST_ADR = AW'(MAX_ENTRIES - 1);

   logic [LINK_W-1:0] link_mem [MAX_ENTRIES];

   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [LINK_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0]  val_ff, val_in;
   logic               skip_ff, skip_in;
   logic [LINK_W-1:0]  link_ff, link_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               err_ff, err_in;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [POS_W-1:0]   scan_end_ff, scan_end_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [POS_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [LINK_W-1:0]  rdata_ff;
   logic [DC_W-1:0]    dc_ff, dc_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LINK_W-1:0]  rsp_link_ff, rsp_link_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               cur_ok;
   logic               scan_more;
   logic               scan_issue;
   logic [POS_W-1:0]   dc_end;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [LINK_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   assign cur_ok     = {1'b0, cur_ff} < MAX_POS;
   assign scan_more  = scan_addr_ff < scan_end_ff;
   assign scan_issue = cmd.scan_step && scan_more;
   assign dc_end     = POS_W'(dc_ff) + POS_W'(2);

   always_comb begin
      mem_we    = cmd.clear_wr || (cmd.wr_cur && cur_ok) || cmd.chain_wr;
      mem_waddr = cmd.clear_wr ? clr_ff : cur_ff[AW-1:0];
      if (cmd.clear_wr) begin
         if (clr_ff == AW'(0)) begin
            mem_wdata = MEDIA_LINK;
         end else if (clr_ff == AW'(1)) begin
            mem_wdata = END_MARK;
         end else begin
            mem_wdata = '0;
         end
      end else if (cmd.wr_cur) begin
         mem_wdata = val_ff;
      end else begin
         mem_wdata = '0;
      end
      mem_re    = cmd.rd_cur || cmd.chain_rd || scan_issue;
      mem_raddr = scan_issue ? scan_addr_ff[AW-1:0] : cur_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= link_mem[mem_raddr];
      end
   end

   always_comb begin
      func_in      = func_ff;
      cur_in       = cur_ff;
      val_in       = val_ff;
      skip_in      = skip_ff;
      link_in      = link_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      found_in     = found_ff;
      scan_addr_in = scan_addr_ff;
      scan_end_in  = scan_end_ff;
      rd_pend_in   = rd_pend_ff;
      rd_addr_in   = rd_addr_ff;
      dc_in        = csr_valid ? csr_data : dc_ff;
      clr_in       = cmd.clear_wr ? clr_ff + AW'(1) : clr_ff;
      rsp_link_in  = rsp_link_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (cmd.load_req) begin
         func_in      = req_func;
         cur_in       = LINK_W'(req_index);
         val_in       = req_value;
         skip_in      = (req_func == FUNC_FIND2);
         link_in      = '0;
         count_in     = '0;
         err_in       = 1'b0;
         found_in     = 1'b0;
         scan_addr_in = POS_W'(2);
         scan_end_in  = (dc_end > MAX_POS) ? MAX_POS : dc_end;
         rd_pend_in   = 1'b0;
      end
      if (cmd.take_read) begin
         link_in = cur_ok ? rdata_ff : '0;
      end
      if (cmd.chain_wr) begin
         cur_in   = rdata_ff;
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.set_err) begin
         err_in = 1'b1;
      end
      if (cmd.scan_step) begin
         rd_pend_in = scan_issue;
         rd_addr_in = scan_addr_ff;
         if (scan_issue) begin
            scan_addr_in = scan_addr_ff + POS_W'(1);
         end
         // returned entry from the previous cycle
         if (rd_pend_ff && rdata_ff == '0 && !found_ff) begin
            if (func_ff == FUNC_COUNT) begin
               count_in = count_ff + COUNT_W'(1);
            end else if (skip_ff) begin
               skip_in = 1'b0;
            end else begin
               link_in  = rd_addr_ff[LINK_W-1:0];
               found_in = 1'b1;
            end
         end
      end
      if (cmd.load_out) begin
         rsp_link_in  = link_ff;
         rsp_count_in = count_ff;
         rsp_err_in   = err_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff        <= DC_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         dc_ff        <= dc_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      cur_ff       <= cur_in;
      val_ff       <= val_in;
      skip_ff      <= skip_in;
      link_ff      <= link_in;
      count_ff     <= count_in;
      err_ff       <= err_in;
      scan_addr_ff <= scan_addr_in;
      scan_end_ff  <= scan_end_in;
      rd_addr_ff   <= rd_addr_in;
      rsp_link_ff  <= rsp_link_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_comb begin
      status.clr_last   = (clr_ff == LAST_ADR);
      status.chain_stop = !cur_ok || (count_ff >= dc_ff);
      status.end_mark   = (rdata_ff == END_MARK);
      status.scan_done  = found_ff || (!rd_pend_ff && !scan_more);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_link   = rsp_link_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_err    = rsp_err_ff;

   a_wr_in_table: assert property (@(posedge clock) disable iff (reset)
      (mem_we && !cmd.clear_wr) |-> cur_ok)
      else $error("table write outside the table");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |-> (link_ff >= LINK_W'(2) && POS_W'(link_ff) < scan_end_ff))
      else $error("found index outside scan range");

   a_chain_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.chain_wr |=> (count_ff <= dc_ff))
      else $error("chain free exceeded step bound");

endmodule
`default_nettype wire

@@ rtl/fct_controller.sv @@
`default_nettype none
module fct_controller import fct_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire status_type        status,
   output cmd_type                cmd
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_READ      = 4'd2;
   localparam logic [3:0] S_READ_WAIT = 4'd3;
   localparam logic [3:0] S_WRITE     = 4'd4;
   localparam logic [3:0] S_CHAIN_RD  = 4'd5;
   localparam logic [3:0] S_CHAIN_WR  = 4'd6;
   localparam logic [3:0] S_SCAN      = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               case (req_func)
                  FUNC_READ:  state_in = S_READ;
                  FUNC_WRITE: state_in = S_WRITE;
                  FUNC_FREE:  state_in = S_CHAIN_RD;
                  FUNC_FIND1: state_in = S_SCAN;
                  FUNC_FIND2: state_in = S_SCAN;
                  FUNC_COUNT: state_in = S_SCAN;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_READ: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            cmd.take_read = 1'b1;
            state_in      = S_DONE;
         end
         S_WRITE: begin
            cmd.wr_cur = 1'b1;
            state_in   = S_DONE;
         end
         S_CHAIN_RD: begin
            if (status.chain_stop) begin
               cmd.set_err = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.chain_rd = 1'b1;
               state_in     = S_CHAIN_WR;
            end
         end
         S_CHAIN_WR: begin
            // clear current entry and follow its old link
            cmd.chain_wr = 1'b1;
            state_in     = status.end_mark ? S_DONE : S_CHAIN_RD;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE && state_ff != S_CLEAR))
      else $error("request transfer did not start an operation");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |=> (state_ff != S_CLEAR))
      else $error("clearing sweep re-entered");

   a_out_from_done: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (state_ff == S_IDLE))
      else $error("result loaded outside completion");

endmodule
`default_nettype wire

@@ rtl/fat12_cluster_table_engine_unit.sv @@
`default_nettype none
// each operation ends in the result transfer: read, write, unused code, chain free (link
// by link, with an error stop when the walk is cut short), and scans over the entries
// scanned (data_clusters clipped to the table), one entry per cycle through the single
// table read port; one request in flight, so a new request is taken only once the last
// is through, and the output register lets the next request transfer while a result waits
// reset: synchronous, then a clearing sweep of MAX_ENTRIES entries, requests held off, csr open
module fat12_cluster_table_engine_unit import fct_pkg::*; #(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,  // cluster_index[9:0], entry_value[21:10], zero pad
   input  wire logic [2:0]   req_tuser,  // func[2:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [23:0]       rsp_tdata,  // link_value[11:0], cluster_count[21:12], zero pad
   output logic [0:0]        rsp_tuser,  // walk_error[0]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [9:0]   csr_data    // data_clusters
);

   cmd_type            cmd;
   status_type         status;
   logic [LINK_W-1:0]  rsp_link;
   logic [COUNT_W-1:0] rsp_count;
   logic               rsp_err;

   fct_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   fct_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_func   (req_tuser),
      .req_index  (req_tdata[9:0]),
      .req_value  (req_tdata[21:10]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_link   (rsp_link),
      .rsp_count  (rsp_count),
      .rsp_err    (rsp_err)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {2'b00, rsp_count, rsp_link};
   assign rsp_tuser = rsp_err;

endmodule
`default_nettype wire
